### rtl/core/ray_box_slab_intersect_defines.svh
// Assertion macros for the ray/box slab intersection block.
// Used by ray_box_slab_intersect.sv; expects signals named clock and reset in scope.
`ifndef RAY_BOX_SLAB_INTERSECT_DEFINES_SVH
`define RAY_BOX_SLAB_INTERSECT_DEFINES_SVH

// same-cycle implication, checked outside reset
`define RBSI_ASSERT_IMP(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, checked outside reset
`define RBSI_ASSERT_NXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/core/rbsi_pkg.sv
// Shared constants and types for the ray/box slab intersection block.
// No dependencies; used by every module of the block except rbsi_div_pipe.
`timescale 1ns / 1ps

package rbsi_pkg;

   localparam int COORD_WIDTH_DEF = 32;
   localparam int DIR_WIDTH       = 32;
   localparam int QUOT_SHIFT      = 29;
   localparam int NUM_LANES       = 3;
   localparam int CSR_IDX_WIDTH   = 3;

   localparam logic [DIR_WIDTH-1:0] DIR_Z_RESET = 32'hC000_0000;

   typedef enum logic [CSR_IDX_WIDTH-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_DIR_X    = 3'd3,
      CSR_DIR_Y    = 3'd4,
      CSR_DIR_Z    = 3'd5
   } csr_index_type;

   // per-slab flags carried alongside the divider pipeline
   typedef struct packed {
      logic neg_t1;
      logic neg_t2;
      logic dir_zero;
      logic in_range;
   } slab_side_type;

   // per-slab outcome handed to the merge stage
   typedef struct packed {
      logic bounded;
      logic ok;
   } lane_flag_type;

endpackage

### rtl/core/ray_box_slab_intersect.sv
// Ray/box slab test: one request carries a box (centre and full size per axis) and gives
// one result, a hit flag and the latest slab entry distance (Q16.16, saturated; 0 on a
// miss). Ray origin and direction sit in six registers written through the csr_ port; the
// user must write them only while no request is in flight, the block does not enforce it.
// One request is accepted every cycle while no result is stalled. The pipeline depth is
// set by the bit-per-stage divider pipelines in the three axis lanes. When a result is
// stalled, the whole pipeline and the request side hold until it is taken.
// Depends on rbsi_pkg, rbsi_slab_lane, rbsi_div_pipe and rbsi_merge.
`timescale 1ns / 1ps
`include "ray_box_slab_intersect_defines.svh"

module ray_box_slab_intersect #(
   parameter int COORD_WIDTH = rbsi_pkg::COORD_WIDTH_DEF
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic signed [COORD_WIDTH-1:0]         req_center_x,
   input  logic signed [COORD_WIDTH-1:0]         req_center_y,
   input  logic signed [COORD_WIDTH-1:0]         req_center_z,
   input  logic        [COORD_WIDTH-2:0]         req_extent_x,
   input  logic        [COORD_WIDTH-2:0]         req_extent_y,
   input  logic        [COORD_WIDTH-2:0]         req_extent_z,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_hit,
   output logic signed [COORD_WIDTH-1:0]         rsp_entry_distance,
   input  logic                                  csr_write_en,
   input  logic [rbsi_pkg::CSR_IDX_WIDTH-1:0]    csr_index,
   input  logic [((COORD_WIDTH > rbsi_pkg::DIR_WIDTH) ? COORD_WIDTH
                  : rbsi_pkg::DIR_WIDTH)-1:0]    csr_wdata
);

   localparam int DVW        = rbsi_pkg::DIR_WIDTH;
   localparam int NW         = COORD_WIDTH + 2 + rbsi_pkg::QUOT_SHIFT;
   localparam int QW         = NW + 1;
   localparam int PIPE_DEPTH = NW + 3;

   logic signed [COORD_WIDTH-1:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic signed [DVW-1:0]         dir_x_ff, dir_y_ff, dir_z_ff;
   logic                          adv;
   logic [PIPE_DEPTH-1:0]         vld_ff;
   logic                          rsp_valid_ff;
   logic signed [QW-1:0]          lane_lo [rbsi_pkg::NUM_LANES];
   logic signed [QW-1:0]          lane_hi [rbsi_pkg::NUM_LANES];
   rbsi_pkg::lane_flag_type       lane_flag [rbsi_pkg::NUM_LANES];

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
         dir_x_ff    <= '0;
         dir_y_ff    <= '0;
         dir_z_ff    <= rbsi_pkg::DIR_Z_RESET;
      end else if (csr_write_en) begin
         unique case (rbsi_pkg::csr_index_type'(csr_index))
            rbsi_pkg::CSR_ORIGIN_X: origin_x_ff <= csr_wdata[COORD_WIDTH-1:0];
            rbsi_pkg::CSR_ORIGIN_Y: origin_y_ff <= csr_wdata[COORD_WIDTH-1:0];
            rbsi_pkg::CSR_ORIGIN_Z: origin_z_ff <= csr_wdata[COORD_WIDTH-1:0];
            rbsi_pkg::CSR_DIR_X:    dir_x_ff    <= csr_wdata[DVW-1:0];
            rbsi_pkg::CSR_DIR_Y:    dir_y_ff    <= csr_wdata[DVW-1:0];
            rbsi_pkg::CSR_DIR_Z:    dir_z_ff    <= csr_wdata[DVW-1:0];
            default: ;
         endcase
      end
   end

   // advance everything unless a finished result is being held
   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         vld_ff       <= {vld_ff[PIPE_DEPTH-2:0], req_valid};
         rsp_valid_ff <= vld_ff[PIPE_DEPTH-1];
      end
   end

   rbsi_slab_lane #(.CW(COORD_WIDTH), .QW(QW)) u_lane_x (
      .clock   (clock),
      .adv     (adv),
      .center  (req_center_x),
      .extent  (req_extent_x),
      .origin  (origin_x_ff),
      .dir     (dir_x_ff),
      .lo_ff   (lane_lo[0]),
      .hi_ff   (lane_hi[0]),
      .flag_ff (lane_flag[0])
   );

   rbsi_slab_lane #(.CW(COORD_WIDTH), .QW(QW)) u_lane_y (
      .clock   (clock),
      .adv     (adv),
      .center  (req_center_y),
      .extent  (req_extent_y),
      .origin  (origin_y_ff),
      .dir     (dir_y_ff),
      .lo_ff   (lane_lo[1]),
      .hi_ff   (lane_hi[1]),
      .flag_ff (lane_flag[1])
   );

   rbsi_slab_lane #(.CW(COORD_WIDTH), .QW(QW)) u_lane_z (
      .clock   (clock),
      .adv     (adv),
      .center  (req_center_z),
      .extent  (req_extent_z),
      .origin  (origin_z_ff),
      .dir     (dir_z_ff),
      .lo_ff   (lane_lo[2]),
      .hi_ff   (lane_hi[2]),
      .flag_ff (lane_flag[2])
   );

   rbsi_merge #(.CW(COORD_WIDTH), .QW(QW)) u_merge (
      .clock    (clock),
      .adv      (adv),
      .lo       (lane_lo),
      .hi       (lane_hi),
      .flag     (lane_flag),
      .hit_ff   (rsp_hit),
      .entry_ff (rsp_entry_distance)
   );

   assign rsp_valid = rsp_valid_ff;

   `RBSI_ASSERT_IMP(a_req_stall_cause, req_stall, rsp_valid && rsp_stall, "stray stall")
   `RBSI_ASSERT_NXT(a_req_enters_pipe, req_valid && !req_stall, vld_ff[0], "request lost")
   `RBSI_ASSERT_NXT(a_pipe_holds, rsp_valid && rsp_stall, $stable(vld_ff), "pipe moved")

endmodule

### rtl/core/rbsi_div_pipe.sv
// Pipelined restoring divider, one quotient bit per stage.
// Uses no package items; instantiated by rbsi_slab_lane.
`timescale 1ns / 1ps

module rbsi_div_pipe #(
   parameter int NW  = 63,
   parameter int DVW = 32
) (
   input  logic           clock,
   input  logic           adv,
   input  logic [NW-1:0]  num_in,
   input  logic [DVW-1:0] den,
   output logic [NW-1:0]  quo
);

   logic [NW-1:0]  word_ff [NW];
   logic [DVW-1:0] rem_ff  [NW-1];

   genvar k;
   generate
      for (k = 0; k < NW; k++) begin : g_stage
         logic [NW-1:0]  word_s;
         logic [DVW-1:0] rem_s;
         logic [DVW:0]   trial;
         logic [DVW:0]   diff;
         logic           qb;

         if (k == 0) begin : g_first
            assign word_s = num_in;
            assign rem_s  = '0;
         end else begin : g_rest
            assign word_s = word_ff[k-1];
            assign rem_s  = rem_ff[k-1];
         end

         assign trial = {rem_s, word_s[NW-1]};
         assign qb    = (trial >= {1'b0, den});
         assign diff  = trial - {1'b0, den};

         // shift numerator out at the top, quotient bit in at the bottom
         always_ff @(posedge clock) begin
            if (adv) begin
               word_ff[k] <= {word_s[NW-2:0], qb};
            end
         end

         if (k < NW-1) begin : g_rem
            always_ff @(posedge clock) begin
               if (adv) begin
                  rem_ff[k] <= qb ? diff[DVW-1:0] : trial[DVW-1:0];
               end
            end
         end
      end
   endgenerate

   assign quo = word_ff[NW-1];

endmodule

### rtl/core/rbsi_slab_lane.sv
// One axis of the slab test: bound offsets, two pipelined divisions, entry/exit order.
// Depends on rbsi_pkg and rbsi_div_pipe.
`timescale 1ns / 1ps

module rbsi_slab_lane #(
   parameter int CW = rbsi_pkg::COORD_WIDTH_DEF,
   parameter int QW = CW + 3 + rbsi_pkg::QUOT_SHIFT
) (
   input  logic                               clock,
   input  logic                               adv,
   input  logic signed [CW-1:0]               center,
   input  logic        [CW-2:0]               extent,
   input  logic signed [CW-1:0]               origin,
   input  logic signed [rbsi_pkg::DIR_WIDTH-1:0] dir,
   output logic signed [QW-1:0]               lo_ff,
   output logic signed [QW-1:0]               hi_ff,
   output rbsi_pkg::lane_flag_type            flag_ff
);

   localparam int DW  = CW + 3;
   localparam int MW  = CW + 2;
   localparam int NW  = MW + rbsi_pkg::QUOT_SHIFT;
   localparam int DVW = rbsi_pkg::DIR_WIDTH;

   logic signed [DW-1:0] cen2, org2, ext_w;
   logic signed [DW-1:0] dmin_in, dmax_in, dmin_ff, dmax_ff;
   logic        [DW-1:0] mag1, mag2;
   logic        [NW-1:0] num1, num2, q1, q2;
   logic        [DVW-1:0] den;
   logic                 dir_neg;
   rbsi_pkg::slab_side_type side_in, side_out;
   rbsi_pkg::slab_side_type side_ff [NW];
   logic signed [QW-1:0] t1, t2, lo_in, hi_in;
   rbsi_pkg::lane_flag_type flag_in;

   // bounds doubled so the half extent stays exact
   assign cen2    = {{2{center[CW-1]}}, center, 1'b0};
   assign org2    = {{2{origin[CW-1]}}, origin, 1'b0};
   assign ext_w   = {4'b0, extent};
   assign dmin_in = cen2 - ext_w - org2;
   assign dmax_in = cen2 + ext_w - org2;

   always_ff @(posedge clock) begin
      if (adv) begin
         dmin_ff <= dmin_in;
         dmax_ff <= dmax_in;
      end
   end

   assign dir_neg = dir[DVW-1];
   assign den     = dir_neg ? (DVW'(0) - dir) : dir;
   assign mag1    = dmin_ff[DW-1] ? (DW'(0) - dmin_ff) : dmin_ff;
   assign mag2    = dmax_ff[DW-1] ? (DW'(0) - dmax_ff) : dmax_ff;
   assign num1    = {mag1[MW-1:0], {rbsi_pkg::QUOT_SHIFT{1'b0}}};
   assign num2    = {mag2[MW-1:0], {rbsi_pkg::QUOT_SHIFT{1'b0}}};

   always_comb begin
      side_in.neg_t1   = dmin_ff[DW-1] ^ dir_neg;
      side_in.neg_t2   = dmax_ff[DW-1] ^ dir_neg;
      side_in.dir_zero = (dir == '0);
      side_in.in_range = (dmin_ff[DW-1] || (dmin_ff == '0)) && !dmax_ff[DW-1];
   end

   rbsi_div_pipe #(.NW(NW), .DVW(DVW)) u_div_t1 (
      .clock  (clock),
      .adv    (adv),
      .num_in (num1),
      .den    (den),
      .quo    (q1)
   );

   rbsi_div_pipe #(.NW(NW), .DVW(DVW)) u_div_t2 (
      .clock  (clock),
      .adv    (adv),
      .num_in (num2),
      .den    (den),
      .quo    (q2)
   );

   // carry the sign, zero-direction and in-range flags beside the divider stages
   always_ff @(posedge clock) begin
      if (adv) begin
         side_ff[0] <= side_in;
         for (int i = 1; i < NW; i++) begin
            side_ff[i] <= side_ff[i-1];
         end
      end
   end
   assign side_out = side_ff[NW-1];

   assign t1 = side_out.neg_t1 ? (QW'(0) - QW'(q1)) : QW'(q1);
   assign t2 = side_out.neg_t2 ? (QW'(0) - QW'(q2)) : QW'(q2);

   always_comb begin
      lo_in           = (t1 < t2) ? t1 : t2;
      hi_in           = (t1 < t2) ? t2 : t1;
      flag_in.bounded = !side_out.dir_zero;
      flag_in.ok      = side_out.dir_zero ? side_out.in_range : 1'b1;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         lo_ff   <= lo_in;
         hi_ff   <= hi_in;
         flag_ff <= flag_in;
      end
   end

endmodule

### rtl/core/rbsi_merge.sv
// Merge of the three slab results: latest entry, earliest exit, hit decision, saturation.
// Depends on rbsi_pkg; instantiated by ray_box_slab_intersect.
`timescale 1ns / 1ps

module rbsi_merge #(
   parameter int CW = rbsi_pkg::COORD_WIDTH_DEF,
   parameter int QW = CW + 3 + rbsi_pkg::QUOT_SHIFT
) (
   input  logic                    clock,
   input  logic                    adv,
   input  logic signed [QW-1:0]    lo   [rbsi_pkg::NUM_LANES],
   input  logic signed [QW-1:0]    hi   [rbsi_pkg::NUM_LANES],
   input  rbsi_pkg::lane_flag_type flag [rbsi_pkg::NUM_LANES],
   output logic                    hit_ff,
   output logic signed [CW-1:0]    entry_ff
);

   localparam logic [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};
   localparam logic [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};

   logic signed [QW-1:0] tmin_in, tmax_in, tmin_ff, tmax_ff;
   logic                 tmin_any_in, tmax_any_in, ok_in;
   logic                 tmin_any_ff, tmax_any_ff, ok_ff;
   logic                 neg_tmax, crossed, fits, hit_in;
   logic [QW-CW:0]       upper;
   logic [CW-1:0]        entry_val, entry_in;

   always_comb begin
      tmin_in     = '0;
      tmax_in     = '0;
      tmin_any_in = 1'b0;
      tmax_any_in = 1'b0;
      ok_in       = 1'b1;
      for (int i = 0; i < rbsi_pkg::NUM_LANES; i++) begin
         ok_in = ok_in & flag[i].ok;
         if (flag[i].bounded) begin
            if (!tmin_any_in || (lo[i] > tmin_in)) begin
               tmin_in = lo[i];
            end
            if (!tmax_any_in || (hi[i] < tmax_in)) begin
               tmax_in = hi[i];
            end
            tmin_any_in = 1'b1;
            tmax_any_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         tmin_ff     <= tmin_in;
         tmax_ff     <= tmax_in;
         tmin_any_ff <= tmin_any_in;
         tmax_any_ff <= tmax_any_in;
         ok_ff       <= ok_in;
      end
   end

   assign neg_tmax = tmax_any_ff && tmax_ff[QW-1];
   assign crossed  = tmin_any_ff && tmax_any_ff && (tmin_ff > tmax_ff);
   assign hit_in   = ok_ff && !neg_tmax && !crossed;

   // no clamp needed when all bits above the field agree with its sign bit
   assign upper = tmin_ff[QW-1:CW-1];
   assign fits  = (&upper) || !(|upper);

   always_comb begin
      if (!tmin_any_ff) begin
         entry_val = SAT_MIN;
      end else if (fits) begin
         entry_val = tmin_ff[CW-1:0];
      end else begin
         entry_val = tmin_ff[QW-1] ? SAT_MIN : SAT_MAX;
      end
      entry_in = hit_in ? entry_val : '0;
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         hit_ff   <= hit_in;
         entry_ff <= entry_in;
      end
   end

endmodule

### verif/ray_box_slab_checker.sv
// Checker for the ray/box slab intersection block: tracks register writes, predicts the
// hit flag and entry distance of every accepted request and compares against the results.
// Depends on rbsi_pkg for the register index codes, the direction reset value and the quotient shift.
`timescale 1ns / 1ps

module ray_box_slab_checker (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   input  logic               req_stall,
   input  logic signed [31:0] req_center_x,
   input  logic signed [31:0] req_center_y,
   input  logic signed [31:0] req_center_z,
   input  logic        [30:0] req_extent_x,
   input  logic        [30:0] req_extent_y,
   input  logic        [30:0] req_extent_z,
   input  logic               rsp_valid,
   input  logic               rsp_stall,
   input  logic               rsp_hit,
   input  logic signed [31:0] rsp_entry_distance,
   input  logic               csr_write_en,
   input  logic [rbsi_pkg::CSR_IDX_WIDTH-1:0] csr_index,
   input  logic [31:0]        csr_wdata,
   output int                 fail_count,
   output int                 pending,
   output int                 hit_count
);

   typedef struct packed {
      logic               hit;
      logic signed [31:0] entry;
   } box_result_type;

   localparam longint FAR_LO = 64'sh8000_0000_0000_0000;
   localparam longint FAR_HI = 64'sh7FFF_FFFF_FFFF_FFFF;

   logic signed [31:0] ray_org [3];
   logic signed [31:0] ray_dir [3];
   box_result_type     expected_q [$];

   // magnitude truncated toward zero, result in Q16.16
   function automatic longint slab_quot(longint num, longint den);
      logic neg;
      longint unsigned un, ud, q;
      neg = (num < 0) != (den < 0);
      un = (num < 0) ? -num : num;
      ud = (den < 0) ? -den : den;
      q = ((un << rbsi_pkg::QUOT_SHIFT) / ud) & 64'h7FFF_FFFF_FFFF_FFFF;
      return neg ? -longint'(q) : longint'(q);
   endfunction

   function automatic box_result_type predict_box(logic signed [31:0] cen [3],
                                                   logic [30:0] ext [3]);
      longint t_enter, t_leave, dlo, dhi, t1, t2, lo, hi;
      logic meets;
      box_result_type r;
      t_enter = FAR_LO;
      t_leave = FAR_HI;
      meets = 1'b1;
      for (int a = 0; a < 3; a++) begin
         dlo = 2 * longint'(cen[a]) - longint'(ext[a]) - 2 * longint'(ray_org[a]);
         dhi = 2 * longint'(cen[a]) + longint'(ext[a]) - 2 * longint'(ray_org[a]);
         if (ray_dir[a] == 0) begin
            lo = FAR_LO;
            hi = FAR_HI;
            if (!(dlo <= 0 && dhi >= 0)) meets = 1'b0;
         end else begin
            t1 = slab_quot(dlo, longint'(ray_dir[a]));
            t2 = slab_quot(dhi, longint'(ray_dir[a]));
            lo = (t1 < t2) ? t1 : t2;
            hi = (t1 < t2) ? t2 : t1;
         end
         if (lo > t_enter) t_enter = lo;
         if (hi < t_leave) t_leave = hi;
      end
      if (t_leave < 0 || t_enter > t_leave) meets = 1'b0;
      r.hit = meets;
      r.entry = '0;
      if (meets) begin
         if (t_enter > 64'sh7FFF_FFFF) r.entry = 32'sh7FFF_FFFF;
         else if (t_enter < -64'sh8000_0000) r.entry = 32'sh8000_0000;
         else r.entry = t_enter[31:0];
      end
      return r;
   endfunction

   always @(posedge clock) begin
      logic signed [31:0] cen [3];
      logic [30:0]        ext [3];
      box_result_type     want;
      if (reset) begin
         ray_org = '{0, 0, 0};
         ray_dir = '{0, 0, rbsi_pkg::DIR_Z_RESET};
         expected_q.delete();
         fail_count <= 0;
         hit_count <= 0;
      end else begin
         if (req_valid && !req_stall) begin
            cen = '{req_center_x, req_center_y, req_center_z};
            ext = '{req_extent_x, req_extent_y, req_extent_z};
            expected_q.push_back(predict_box(cen, ext));
         end
         if (rsp_valid && !rsp_stall) begin
            if (expected_q.size() == 0) begin
               if (fail_count < 10) $display("unexpected result hit=%0b dist=%0d",
                                             rsp_hit, rsp_entry_distance);
               fail_count <= fail_count + 1;
            end else begin
               want = expected_q.pop_front();
               if (want.hit) hit_count <= hit_count + 1;
               if (rsp_hit !== want.hit || rsp_entry_distance !== want.entry) begin
                  if (fail_count < 10)
                     $display("result differs: hit exp %0b got %0b, dist exp %0d got %0d",
                              want.hit, rsp_hit, want.entry, rsp_entry_distance);
                  fail_count <= fail_count + 1;
               end
            end
         end
         // register update takes effect for requests after this edge
         if (csr_write_en) begin
            unique case (csr_index)
               rbsi_pkg::CSR_ORIGIN_X: ray_org[0] = csr_wdata;
               rbsi_pkg::CSR_ORIGIN_Y: ray_org[1] = csr_wdata;
               rbsi_pkg::CSR_ORIGIN_Z: ray_org[2] = csr_wdata;
               rbsi_pkg::CSR_DIR_X:    ray_dir[0] = csr_wdata;
               rbsi_pkg::CSR_DIR_Y:    ray_dir[1] = csr_wdata;
               rbsi_pkg::CSR_DIR_Z:    ray_dir[2] = csr_wdata;
               default: ;
            endcase
         end
      end
      pending = expected_q.size();
   end

endmodule

### verif/ray_box_slab_intersect_tb.sv
// Top of the ray/box slab intersection testbench: clock, reset, ray settings, box requests
// and receiver stalls; checking sits in ray_box_slab_checker.
// Depends on rbsi_pkg, ray_box_slab_intersect and ray_box_slab_checker.
`timescale 1ns / 1ps

module ray_box_slab_intersect_tb;

   localparam logic [rbsi_pkg::CSR_IDX_WIDTH-1:0] CSR_SPARE = 3'd6;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT = 600000;
   localparam logic signed [31:0] DIR_ONE = 32'sh4000_0000;

   logic clock, reset;
   logic req_valid, req_stall, rsp_valid, rsp_stall, rsp_hit;
   logic signed [31:0] req_center_x, req_center_y, req_center_z, rsp_entry_distance;
   logic [30:0] req_extent_x, req_extent_y, req_extent_z;
   logic csr_write_en;
   logic [rbsi_pkg::CSR_IDX_WIDTH-1:0] csr_index;
   logic [31:0] csr_wdata;
   int fail_count, pending, hit_count;
   int cycles = 0;
   int sent, settings;
   logic long_hold;
   logic signed [31:0] cur_org [3];
   logic signed [31:0] cur_dir [3];

   ray_box_slab_intersect dut (.*);

   ray_box_slab_checker checker_i (.*);

   initial begin
      clock = 0;
      forever #4 clock = ~clock;
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycles);
         $display("ray_box_slab_intersect: mismatch");
         $finish;
      end
   end

   // receiver: switch stall pattern now and then; hold off for a long stretch on request
   initial begin
      int mode, left, hold;
      rsp_stall = 1'b0;
      mode = 0;
      left = 0;
      forever begin
         @(negedge clock);
         if (long_hold) begin
            hold = 400;
            while (hold > 0) begin
               rsp_stall <= 1'b1;
               hold--;
               @(negedge clock);
            end
         end
         if (left == 0) begin
            mode = $urandom_range(0, 3);
            left = $urandom_range(10, 200);
         end
         left--;
         case (mode)
            0: rsp_stall <= 1'b0;
            1: rsp_stall <= ($urandom_range(0, 99) < 30);
            2: rsp_stall <= (left % 4 == 0);
            default: rsp_stall <= ($urandom_range(0, 99) < 75);
         endcase
      end
   end

   task automatic write_reg(logic [rbsi_pkg::CSR_IDX_WIDTH-1:0] idx, logic [31:0] value);
      @(negedge clock);
      csr_write_en <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(negedge clock);
      csr_write_en <= 1'b0;
   endtask

   task automatic set_ray(logic signed [31:0] ox, oy, oz, dx, dy, dz);
      cur_org = '{ox, oy, oz};
      cur_dir = '{dx, dy, dz};
      write_reg(rbsi_pkg::CSR_ORIGIN_X, ox);
      write_reg(rbsi_pkg::CSR_ORIGIN_Y, oy);
      write_reg(rbsi_pkg::CSR_ORIGIN_Z, oz);
      write_reg(rbsi_pkg::CSR_DIR_X, dx);
      write_reg(rbsi_pkg::CSR_DIR_Y, dy);
      write_reg(rbsi_pkg::CSR_DIR_Z, dz);
      settings++;
   endtask

   // offer one request and hold it until accepted, then maybe leave a gap
   task automatic send_box(logic signed [31:0] cx, cy, cz, logic [30:0] ex, ey, ez,
                           int gap);
      @(negedge clock);
      req_valid <= 1'b1;
      req_center_x <= cx;
      req_center_y <= cy;
      req_center_z <= cz;
      req_extent_x <= ex;
      req_extent_y <= ey;
      req_extent_z <= ez;
      do @(posedge clock); while (req_stall);
      sent++;
      if (gap > 0) begin
         @(negedge clock);
         req_valid <= 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   task automatic drain();
      @(negedge clock);
      req_valid <= 1'b0;
      wait (pending == 0);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_dir();
      if ($urandom_range(0, 5) == 0) return 0;
      return $signed($urandom_range(0, 32'h8000_0000)) - DIR_ONE;
   endfunction

   // random box: mostly placed around a point of the ray, the rest pure noise
   task automatic random_boxes(int count);
      logic signed [31:0] c [3];
      logic [30:0] e [3];
      longint t;
      int burst, gap;
      burst = 0;
      for (int n = 0; n < count; n++) begin
         if ($urandom_range(0, 3) == 0) begin
            c = '{$urandom(), $urandom(), $urandom()};
            e = '{31'($urandom()), 31'($urandom()), 31'($urandom())};
         end else begin
            t = longint'($urandom_range(0, 32'h0020_0000)) - 64'sh4_0000;
            for (int a = 0; a < 3; a++) begin
               c[a] = cur_org[a] + 32'((t * cur_dir[a]) >>> 30)
                      + $signed($urandom_range(0, 32'h2_0000)) - 32'sh1_0000;
               e[a] = ($urandom_range(0, 7) == 0) ? 31'($urandom())
                                                  : 31'($urandom_range(0, 32'h4_0000));
            end
         end
         gap = 0;
         if (burst == 0) begin
            burst = $urandom_range(1, 40);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
         end
         burst--;
         send_box(c[0], c[1], c[2], e[0], e[1], e[2], gap);
      end
   endtask

   initial begin
      sent = 0;
      settings = 1;
      long_hold = 1'b0;
      reset = 1'b1;
      req_valid = 1'b0;
      req_center_x = '0;
      req_center_y = '0;
      req_center_z = '0;
      req_extent_x = '0;
      req_extent_y = '0;
      req_extent_z = '0;
      csr_write_en = 1'b0;
      csr_index = rbsi_pkg::CSR_ORIGIN_X;
      csr_wdata = '0;
      cur_org = '{0, 0, 0};
      cur_dir = '{0, 0, rbsi_pkg::DIR_Z_RESET};
      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // ray after reset: down the z axis from the origin
      send_box(0, 0, -32'sh5_0000, 31'h2_0000, 31'h2_0000, 31'h2_0000, 0);
      send_box(0, 0, 0, 31'h2_0000, 31'h2_0000, 31'h2_0000, 0);      // origin inside
      send_box(0, 0, 32'sh5_0000, 31'h2_0000, 31'h2_0000, 31'h2_0000, 0); // behind
      send_box(32'sh3_0000, 0, -32'sh5_0000, 31'h2_0000, 31'h2_0000, 31'h2_0000, 0);
      send_box(0, 0, 32'sh8000_0000, '0, '0, '0, 0);
      send_box(0, 0, 32'sh8000_0000, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
      send_box(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF,
               31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
      send_box(0, 0, -32'sh1, '0, '0, 31'h2, 3);
      drain();

      // no direction at all: inside every slab is a hit, else a miss
      set_ray(32'sh1_0000, -32'sh1_0000, 0, 0, 0, 0);
      write_reg(CSR_SPARE, 32'hFFFF_FFFF);
      send_box(32'sh1_0000, -32'sh1_0000, 0, 31'h1_0000, 31'h1_0000, 31'h1_0000, 0);
      send_box(0, 0, 0, 31'h2_0000, 31'h2_0000, 31'h2_0000, 0);
      send_box(0, -32'sh1_0000, 0, 31'h2_0000, 31'h2_0000, 31'h2_0000, 0);
      send_box(32'sh8000, -32'sh1_0000, 0, 31'h1_0000, '0, '0, 0);
      drain();

      // extreme origin and unit axes, far boxes push the distance into saturation
      set_ray(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, DIR_ONE, DIR_ONE, DIR_ONE);
      send_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
      send_box(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 31'h10, 31'h10, 31'h10, 2);
      random_boxes(30);
      drain();
      set_ray(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000, -DIR_ONE, -DIR_ONE, -DIR_ONE);
      send_box(32'sh7FFF_FFFF, 32'sh7FFF_FFFF, 32'sh7FFF_FFFF, '0, '0, '0, 0);
      send_box(32'sh8000_0000, 32'sh8000_0000, 32'sh8000_0000,
               31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
      send_box(0, 0, 0, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 31'h7FFF_FFFF, 0);
      random_boxes(30);
      drain();
      set_ray(0, 0, 0, 1, -1, 0);
      random_boxes(30);
      drain();

      for (int p = 0; p < 9; p++) begin
         set_ray($urandom(), $urandom(), $urandom(), rand_dir(), rand_dir(), rand_dir());
         if (p == 3) begin
            // keep offering requests while the result side is held off
            @(negedge clock);
            long_hold <= 1'b1;
            @(negedge clock);
            long_hold <= 1'b0;
         end
         random_boxes(70);
         drain();
      end

      $display("%0d boxes checked over %0d ray settings, %0d hits", sent, settings,
               hit_count);
      if (fail_count == 0 && pending == 0) begin
         $display("ray_box_slab_intersect: match");
      end else begin
         $display("%0d failures, %0d results missing", fail_count, pending);
         $display("ray_box_slab_intersect: mismatch");
      end
      $finish;
   end

endmodule
